FILE: rtl/arpd_pkg.sv
// ----------------------------------------------------------------------------
// arpd_pkg
// Shared types, sizes and codes of the ARP / MAC spoof detector.
// ----------------------------------------------------------------------------
package arpd_pkg;

    // Table sizes
    localparam int IP_ENTRIES    = 256;
    localparam int MAC_ENTRIES   = 256;
    localparam int BCAST_ENTRIES = 64;

    localparam int IP_AW  = $clog2(IP_ENTRIES);
    localparam int MAC_AW = $clog2(MAC_ENTRIES);
    localparam int BC_AW  = $clog2(BCAST_ENTRIES);
    localparam int SCAN_W = (IP_AW > MAC_AW) ? ((IP_AW > BC_AW) ? IP_AW : BC_AW)
                                             : ((MAC_AW > BC_AW) ? MAC_AW : BC_AW);

    localparam logic [IP_AW-1:0]  IP_LAST  = IP_AW'(IP_ENTRIES - 1);
    localparam logic [MAC_AW-1:0] MAC_LAST = MAC_AW'(MAC_ENTRIES - 1);
    localparam logic [BC_AW-1:0]  BC_LAST  = BC_AW'(BCAST_ENTRIES - 1);

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam int          LAA_BIT   = 41;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_FLOOD  = 3'd1;
    localparam logic [2:0] EV_REUSE  = 3'd2;
    localparam logic [2:0] EV_POISON = 3'd3;
    localparam logic [2:0] EV_LAA    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLOOD_WINDOW = 2'd0;
    localparam logic [1:0] CFG_FLOOD_THRESH = 2'd1;
    localparam logic [1:0] CFG_STALE        = 2'd2;
    localparam logic [1:0] CFG_BC_RETAIN    = 2'd3;

    localparam int CFG_DW = 17;

    // Table entries
    typedef struct packed {
        logic [31:0] key;
        logic [47:0] mac;
        logic        laa;
        logic [31:0] seen_sec;
    } ip_ent_t;

    typedef struct packed {
        logic [47:0] key;
        logic [31:0] ip;
    } mac_ent_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] count;
        logic [31:0] win_start;
    } bc_ent_t;

    // Elapsed time, zero when the clock went backwards
    function automatic logic [31:0] age_of(input logic [31:0] now_v, input logic [31:0] then_v);
        logic [31:0] r;
        r = (now_v >= then_v) ? (now_v - then_v) : 32'd0;
        return r;
    endfunction

endpackage

FILE: rtl/arpd_ram.sv
// ----------------------------------------------------------------------------
// arpd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module arpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and a registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/arp_mac_spoof_detector.sv
// ----------------------------------------------------------------------------
// arp_mac_spoof_detector
// Watches MAC/IP pairs for floods, MAC reuse, ARP poisoning and LAA changes;
// age sweeps drop stale bindings and broadcast counters.
// ----------------------------------------------------------------------------
// Each table scan handles an entry in a read state (address), then a compare
// state on the registered RAM data. A broadcast observation scans the counter
// table, other observations the MAC table and, unless the MAC is reused, the
// IP table, an ignored pair nothing. A sweep scans the binding table, then the
// counters, and the MAC table for each stale binding. One transaction at a time.
// Reset clears the valid flip-flops at once; no clearing pass is needed.
module arp_mac_spoof_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [arpd_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [47:0]                 s_src_mac_addr,
    input  logic [31:0]                 s_src_ip_addr,
    input  logic [31:0]                 s_now_sec,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_alarm,
    output logic [2:0]                  m_event_type,
    output logic [47:0]                 m_old_mac_addr,
    output logic [47:0]                 m_new_mac_addr,
    output logic [31:0]                 m_previous_ip,
    output logic [8:0]                  m_removed_count,
    output logic                        m_table_full
);
    import arpd_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE       = 15'b000000000000001,
        ST_MAC_RD     = 15'b000000000000010,
        ST_MAC_CMP    = 15'b000000000000100,
        ST_IP_RD      = 15'b000000000001000,
        ST_IP_CMP     = 15'b000000000010000,
        ST_BC_RD      = 15'b000000000100000,
        ST_BC_CMP     = 15'b000000001000000,
        ST_SW_IP_RD   = 15'b000000010000000,
        ST_SW_IP_CMP  = 15'b000000100000000,
        ST_SW_MAC_RD  = 15'b000001000000000,
        ST_SW_MAC_CMP = 15'b000010000000000,
        ST_SW_RET     = 15'b000100000000000,
        ST_SW_BC_RD   = 15'b001000000000000,
        ST_SW_BC_CMP  = 15'b010000000000000,
        ST_DONE       = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [11:0] flood_window_reg;
    logic [15:0] flood_thresh_reg;
    logic [16:0] stale_reg;
    logic [11:0] bc_retain_reg;

    // Transaction and scan state
    logic [SCAN_W-1:0] idx_reg, idx_next;
    logic [SCAN_W-1:0] free_idx_reg, free_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IP_AW-1:0]  ret_idx_reg, ret_idx_next;
    logic [47:0]       mac_reg, mac_next;
    logic [31:0]       ip_reg, ip_next;
    logic [31:0]       now_reg, now_next;
    logic [47:0]       tgt_mac_reg, tgt_mac_next;

    logic [IP_ENTRIES-1:0]    ip_valid_reg, ip_valid_next;
    logic [MAC_ENTRIES-1:0]   mac_valid_reg, mac_valid_next;
    logic [BCAST_ENTRIES-1:0] bc_valid_reg, bc_valid_next;

    // Result being built
    logic        res_alarm_reg, res_alarm_next;
    logic [2:0]  res_ev_reg, res_ev_next;
    logic [47:0] res_old_reg, res_old_next;
    logic [47:0] res_new_reg, res_new_next;
    logic [31:0] res_prev_reg, res_prev_next;
    logic [8:0]  res_removed_reg, res_removed_next;
    logic        res_full_reg, res_full_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic        m_alarm_reg, m_alarm_next;
    logic [2:0]  m_ev_reg, m_ev_next;
    logic [47:0] m_old_reg, m_old_next;
    logic [47:0] m_new_reg, m_new_next;
    logic [31:0] m_prev_reg, m_prev_next;
    logic [8:0]  m_removed_reg, m_removed_next;
    logic        m_full_reg, m_full_next;

    // Memory ports
    logic             ip_we, mac_we, bc_we;
    logic [IP_AW-1:0] ip_waddr;
    logic [MAC_AW-1:0] mac_waddr;
    logic [BC_AW-1:0] bc_waddr;
    ip_ent_t          ip_wdata, ip_rd;
    mac_ent_t         mac_wdata, mac_rd;
    bc_ent_t          bc_wdata, bc_rd;
    logic [IP_AW-1:0] ii;
    logic [MAC_AW-1:0] mi;
    logic [BC_AW-1:0] bi;

    // Per-cycle helpers
    logic        mac_hit, mac_cur_free;
    logic        ip_hit, ip_cur_free;
    logic        bc_hit, bc_cur_free;
    logic        laa;
    logic        bc_restart;
    logic [15:0] bc_base, bc_cnt;
    logic [31:0] bc_ws;
    logic        ip_stale, bc_old;

    assign ii = idx_reg[IP_AW-1:0];
    assign mi = idx_reg[MAC_AW-1:0];
    assign bi = idx_reg[BC_AW-1:0];

    arpd_ram #(.WIDTH($bits(ip_ent_t)), .DEPTH(IP_ENTRIES)) u_ip_ram (
        .clk(aclk), .we(ip_we), .waddr(ip_waddr), .wdata(ip_wdata),
        .raddr(ii), .rdata(ip_rd)
    );

    arpd_ram #(.WIDTH($bits(mac_ent_t)), .DEPTH(MAC_ENTRIES)) u_mac_ram (
        .clk(aclk), .we(mac_we), .waddr(mac_waddr), .wdata(mac_wdata),
        .raddr(mi), .rdata(mac_rd)
    );

    arpd_ram #(.WIDTH($bits(bc_ent_t)), .DEPTH(BCAST_ENTRIES)) u_bc_ram (
        .clk(aclk), .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata),
        .raddr(bi), .rdata(bc_rd)
    );

    // Compare terms on the registered read data
    always_comb begin
        laa          = mac_reg[LAA_BIT];
        mac_hit      = mac_valid_reg[mi] && (mac_rd.key == mac_reg);
        mac_cur_free = !mac_valid_reg[mi] && !free_found_reg;
        ip_hit       = ip_valid_reg[ii] && (ip_rd.key == ip_reg);
        ip_cur_free  = !ip_valid_reg[ii] && !free_found_reg;
        bc_hit       = bc_valid_reg[bi] && (bc_rd.ip == ip_reg);
        bc_cur_free  = !bc_valid_reg[bi] && !free_found_reg;
        bc_restart   = age_of(now_reg, bc_rd.win_start) > {20'd0, flood_window_reg};
        bc_base      = (bc_hit && !bc_restart) ? bc_rd.count : 16'd0;
        bc_ws        = (bc_hit && !bc_restart) ? bc_rd.win_start : now_reg;
        bc_cnt       = (bc_base == COUNT_MAX) ? COUNT_MAX : bc_base + 16'd1;
        ip_stale     = ip_valid_reg[ii] && (age_of(now_reg, ip_rd.seen_sec) > {15'd0, stale_reg});
        bc_old       = bc_valid_reg[bi] &&
                       (age_of(now_reg, bc_rd.win_start) > {20'd0, bc_retain_reg});
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        free_idx_next    = free_idx_reg;
        free_found_next  = free_found_reg;
        ret_idx_next     = ret_idx_reg;
        mac_next         = mac_reg;
        ip_next          = ip_reg;
        now_next         = now_reg;
        tgt_mac_next     = tgt_mac_reg;
        ip_valid_next    = ip_valid_reg;
        mac_valid_next   = mac_valid_reg;
        bc_valid_next    = bc_valid_reg;
        res_alarm_next   = res_alarm_reg;
        res_ev_next      = res_ev_reg;
        res_old_next     = res_old_reg;
        res_new_next     = res_new_reg;
        res_prev_next    = res_prev_reg;
        res_removed_next = res_removed_reg;
        res_full_next    = res_full_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_alarm_next     = m_alarm_reg;
        m_ev_next        = m_ev_reg;
        m_old_next       = m_old_reg;
        m_new_next       = m_new_reg;
        m_prev_next      = m_prev_reg;
        m_removed_next   = m_removed_reg;
        m_full_next      = m_full_reg;
        ip_we            = 1'b0;
        ip_waddr         = ii;
        ip_wdata         = '{key: ip_reg, mac: mac_reg, laa: laa, seen_sec: now_reg};
        mac_we           = 1'b0;
        mac_waddr        = mi;
        mac_wdata        = '{key: mac_reg, ip: ip_reg};
        bc_we            = 1'b0;
        bc_waddr         = bi;
        bc_wdata         = '{ip: ip_reg, count: bc_cnt, win_start: bc_ws};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mac_next         = s_src_mac_addr;
                    ip_next          = s_src_ip_addr;
                    now_next         = s_now_sec;
                    idx_next         = '0;
                    free_found_next  = 1'b0;
                    res_alarm_next   = 1'b0;
                    res_ev_next      = EV_NONE;
                    res_old_next     = '0;
                    res_new_next     = '0;
                    res_prev_next    = '0;
                    res_removed_next = '0;
                    res_full_next    = 1'b0;
                    if (s_kind) begin
                        state_next = ST_SW_IP_RD;
                    end else if (s_src_ip_addr == 32'd0 || s_src_mac_addr == 48'd0) begin
                        state_next = ST_DONE;
                    end else if (s_src_mac_addr == MAC_BCAST) begin
                        state_next = ST_BC_RD;
                    end else begin
                        state_next = ST_MAC_RD;
                    end
                end
            end

            ST_MAC_RD: state_next = ST_MAC_CMP;

            // Look up the MAC; rebind on reuse, insert when unknown
            ST_MAC_CMP: begin
                if (mac_hit) begin
                    if (mac_rd.ip != ip_reg) begin
                        mac_we         = 1'b1;
                        res_alarm_next = 1'b1;
                        res_ev_next    = EV_REUSE;
                        res_old_next   = mac_reg;
                        res_new_next   = mac_reg;
                        res_prev_next  = mac_rd.ip;
                        state_next     = ST_DONE;
                    end else begin
                        idx_next        = '0;
                        free_found_next = 1'b0;
                        state_next      = ST_IP_RD;
                    end
                end else if (mi == MAC_LAST) begin
                    if (free_found_reg || mac_cur_free) begin
                        mac_we    = 1'b1;
                        mac_waddr = free_found_reg ? free_idx_reg[MAC_AW-1:0] : mi;
                        mac_valid_next[mac_waddr] = 1'b1;
                    end else begin
                        res_full_next = 1'b1;
                    end
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    state_next      = ST_IP_RD;
                end else begin
                    if (mac_cur_free) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    idx_next   = idx_reg + SCAN_W'(1);
                    state_next = ST_MAC_RD;
                end
            end

            ST_IP_RD: state_next = ST_IP_CMP;

            // Look up the IP; flag a changed binding, insert when unknown
            ST_IP_CMP: begin
                if (ip_hit) begin
                    if (ip_rd.mac != mac_reg) begin
                        res_alarm_next = 1'b1;
                        res_ev_next    = (!ip_rd.laa && laa) ? EV_LAA : EV_POISON;
                        res_old_next   = ip_rd.mac;
                        res_new_next   = mac_reg;
                    end
                    ip_we      = 1'b1;
                    state_next = ST_DONE;
                end else if (ii == IP_LAST) begin
                    if (free_found_reg || ip_cur_free) begin
                        ip_we    = 1'b1;
                        ip_waddr = free_found_reg ? free_idx_reg[IP_AW-1:0] : ii;
                        ip_valid_next[ip_waddr] = 1'b1;
                    end else begin
                        res_full_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end else begin
                    if (ip_cur_free) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    idx_next   = idx_reg + SCAN_W'(1);
                    state_next = ST_IP_RD;
                end
            end

            ST_BC_RD: state_next = ST_BC_CMP;

            // Count a broadcast in its window, insert a new counter
            ST_BC_CMP: begin
                if (bc_hit || (bi == BC_LAST && (free_found_reg || bc_cur_free))) begin
                    bc_we = 1'b1;
                    if (!bc_hit) begin
                        bc_waddr = free_found_reg ? free_idx_reg[BC_AW-1:0] : bi;
                        bc_valid_next[bc_waddr] = 1'b1;
                    end
                    if (bc_cnt > flood_thresh_reg) begin
                        res_alarm_next = 1'b1;
                        res_ev_next    = EV_FLOOD;
                        res_old_next   = MAC_BCAST;
                        res_new_next   = MAC_BCAST;
                    end
                    state_next = ST_DONE;
                end else if (bi == BC_LAST) begin
                    res_full_next = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    if (bc_cur_free) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    idx_next   = idx_reg + SCAN_W'(1);
                    state_next = ST_BC_RD;
                end
            end

            ST_SW_IP_RD: state_next = ST_SW_IP_CMP;

            // Drop a stale binding, then chase its MAC entry
            ST_SW_IP_CMP: begin
                if (ip_stale) begin
                    ip_valid_next[ii] = 1'b0;
                    res_removed_next  = res_removed_reg + 9'd1;
                    tgt_mac_next      = ip_rd.mac;
                    ret_idx_next      = ii;
                    idx_next          = '0;
                    state_next        = ST_SW_MAC_RD;
                end else if (ii == IP_LAST) begin
                    idx_next   = '0;
                    state_next = ST_SW_BC_RD;
                end else begin
                    idx_next   = idx_reg + SCAN_W'(1);
                    state_next = ST_SW_IP_RD;
                end
            end

            ST_SW_MAC_RD: state_next = ST_SW_MAC_CMP;

            ST_SW_MAC_CMP: begin
                if (mac_valid_reg[mi] && mac_rd.key == tgt_mac_reg) begin
                    mac_valid_next[mi] = 1'b0;
                    state_next         = ST_SW_RET;
                end else if (mi == MAC_LAST) begin
                    state_next = ST_SW_RET;
                end else begin
                    idx_next   = idx_reg + SCAN_W'(1);
                    state_next = ST_SW_MAC_RD;
                end
            end

            // Resume the binding scan, or move to the counters
            ST_SW_RET: begin
                if (ret_idx_reg == IP_LAST) begin
                    idx_next   = '0;
                    state_next = ST_SW_BC_RD;
                end else begin
                    idx_next   = SCAN_W'(ret_idx_reg) + SCAN_W'(1);
                    state_next = ST_SW_IP_RD;
                end
            end

            ST_SW_BC_RD: state_next = ST_SW_BC_CMP;

            // Drop broadcast counters whose window is too old
            ST_SW_BC_CMP: begin
                if (bc_old) begin
                    bc_valid_next[bi] = 1'b0;
                    res_removed_next  = res_removed_reg + 9'd1;
                end
                if (bi == BC_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + SCAN_W'(1);
                    state_next = ST_SW_BC_RD;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_alarm_next   = res_alarm_reg;
                    m_ev_next      = res_ev_reg;
                    m_old_next     = res_old_reg;
                    m_new_next     = res_new_reg;
                    m_prev_next    = res_prev_reg;
                    m_removed_next = res_removed_reg;
                    m_full_next    = res_full_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            ip_valid_reg     <= '0;
            mac_valid_reg    <= '0;
            bc_valid_reg     <= '0;
            flood_window_reg <= 12'd10;
            flood_thresh_reg <= 16'd50;
            stale_reg        <= 17'd600;
            bc_retain_reg    <= 12'd60;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            ip_valid_reg  <= ip_valid_next;
            mac_valid_reg <= mac_valid_next;
            bc_valid_reg  <= bc_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FLOOD_WINDOW: flood_window_reg <= cfg_wdata[11:0];
                    CFG_FLOOD_THRESH: flood_thresh_reg <= cfg_wdata[15:0];
                    CFG_STALE:        stale_reg        <= cfg_wdata[16:0];
                    CFG_BC_RETAIN:    bc_retain_reg    <= cfg_wdata[11:0];
                    default:          stale_reg        <= stale_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        free_idx_reg    <= free_idx_next;
        free_found_reg  <= free_found_next;
        ret_idx_reg     <= ret_idx_next;
        mac_reg         <= mac_next;
        ip_reg          <= ip_next;
        now_reg         <= now_next;
        tgt_mac_reg     <= tgt_mac_next;
        res_alarm_reg   <= res_alarm_next;
        res_ev_reg      <= res_ev_next;
        res_old_reg     <= res_old_next;
        res_new_reg     <= res_new_next;
        res_prev_reg    <= res_prev_next;
        res_removed_reg <= res_removed_next;
        res_full_reg    <= res_full_next;
        m_alarm_reg     <= m_alarm_next;
        m_ev_reg        <= m_ev_next;
        m_old_reg       <= m_old_next;
        m_new_reg       <= m_new_next;
        m_prev_reg      <= m_prev_next;
        m_removed_reg   <= m_removed_next;
        m_full_reg      <= m_full_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_alarm         = m_alarm_reg;
    assign m_event_type    = m_ev_reg;
    assign m_old_mac_addr  = m_old_reg;
    assign m_new_mac_addr  = m_new_reg;
    assign m_previous_ip   = m_prev_reg;
    assign m_removed_count = m_removed_reg;
    assign m_table_full    = m_full_reg;

endmodule

FILE: rtl/arpd_checker.sv
// ----------------------------------------------------------------------------
// arpd_checker
// Port-level checks on the results of the ARP / MAC spoof detector.
// ----------------------------------------------------------------------------
module arpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_alarm,
    input logic [2:0]  m_event_type,
    input logic [47:0] m_old_mac_addr,
    input logic [47:0] m_new_mac_addr,
    input logic [8:0]  m_removed_count,
    input logic        m_table_full
);
    import arpd_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_type) && $stable(m_old_mac_addr))
        else $error("result changed while stalled");

    // Alarm and event code agree
    a_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_alarm == (m_event_type != EV_NONE)))
        else $error("alarm does not match event code");

    // Flood reports the broadcast address
    a_flood: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_type == EV_FLOOD |->
            m_old_mac_addr == MAC_BCAST && m_new_mac_addr == MAC_BCAST)
        else $error("flood result without broadcast address");

    // Reuse reports the same MAC on both sides
    a_reuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_type == EV_REUSE |-> m_old_mac_addr == m_new_mac_addr)
        else $error("reuse result with differing MACs");

    // A sweep that removed entries raises no alarm and no table-full flag
    a_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_removed_count != 9'd0 |-> !m_alarm && !m_table_full)
        else $error("sweep result carries an alarm");

endmodule

bind arp_mac_spoof_detector arpd_checker u_arpd_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ARP / MAC spoof detector: a directed opening,
// then random observation and sweep traffic across several register settings,
// checked against an in-bench predictor of the binding and counter tables.
// ----------------------------------------------------------------------------
module tb;
    import arpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int POOL_N         = 320;
    localparam int BC_POOL_N      = 80;

    typedef struct {
        bit        kind;
        bit [47:0] mac;
        bit [31:0] ip;
        bit [31:0] now;
    } obs_t;

    typedef struct {
        bit        alarm;
        bit [2:0]  ev;
        bit [47:0] old_mac;
        bit [47:0] new_mac;
        bit [31:0] prev_ip;
        bit [8:0]  removed;
        bit        full;
    } verdict_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [CFG_DW-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [47:0]         s_src_mac_addr;
    logic [31:0]         s_src_ip_addr;
    logic [31:0]         s_now_sec;
    logic                m_valid;
    logic                m_ready;
    logic                m_alarm;
    logic [2:0]          m_event_type;
    logic [47:0]         m_old_mac_addr;
    logic [47:0]         m_new_mac_addr;
    logic [31:0]         m_previous_ip;
    logic [8:0]          m_removed_count;
    logic                m_table_full;

    arp_mac_spoof_detector i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_src_mac_addr  (s_src_mac_addr),
        .s_src_ip_addr   (s_src_ip_addr),
        .s_now_sec       (s_now_sec),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_alarm         (m_alarm),
        .m_event_type    (m_event_type),
        .m_old_mac_addr  (m_old_mac_addr),
        .m_new_mac_addr  (m_new_mac_addr),
        .m_previous_ip   (m_previous_ip),
        .m_removed_count (m_removed_count),
        .m_table_full    (m_table_full)
    );

    // Clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Predictor configuration and tables
    bit [11:0] win_sec;
    bit [15:0] flood_thr;
    bit [16:0] stale_lim;
    bit [11:0] retain_sec;

    bit        ipt_valid [IP_ENTRIES];
    bit [31:0] ipt_key   [IP_ENTRIES];
    bit [47:0] ipt_mac   [IP_ENTRIES];
    bit        ipt_laa   [IP_ENTRIES];
    bit [31:0] ipt_seen  [IP_ENTRIES];
    bit        mact_valid[MAC_ENTRIES];
    bit [47:0] mact_key  [MAC_ENTRIES];
    bit [31:0] mact_ip   [MAC_ENTRIES];
    bit        bct_valid [BCAST_ENTRIES];
    bit [31:0] bct_ip    [BCAST_ENTRIES];
    bit [15:0] bct_count [BCAST_ENTRIES];
    bit [31:0] bct_start [BCAST_ENTRIES];

    obs_t      pending_obs[$];
    verdict_t  expected_verdicts[$];
    int        n_queued, n_sent, n_checked, n_mismatch, n_alarms, n_full, n_sweeps;

    function automatic bit [31:0] elapsed(bit [31:0] now_v, bit [31:0] then_v);
        return (now_v >= then_v) ? now_v - then_v : 32'd0;
    endfunction

    function automatic int lookup_ip(bit [31:0] ip);
        for (int k = 0; k < IP_ENTRIES; k++)
            if (ipt_valid[k] && ipt_key[k] == ip) return k;
        return -1;
    endfunction

    function automatic int lookup_mac(bit [47:0] mac);
        for (int k = 0; k < MAC_ENTRIES; k++)
            if (mact_valid[k] && mact_key[k] == mac) return k;
        return -1;
    endfunction

    // Apply one transaction to the tables and return its verdict
    function automatic verdict_t judge_obs(obs_t o);
        verdict_t v;
        int       i;
        int       j;
        bit       laa;
        v = '{default: '0};
        if (o.kind) begin
            for (i = 0; i < IP_ENTRIES; i++) begin
                if (ipt_valid[i] && elapsed(o.now, ipt_seen[i]) > stale_lim) begin
                    j = lookup_mac(ipt_mac[i]);
                    if (j >= 0) mact_valid[j] = 1'b0;
                    ipt_valid[i] = 1'b0;
                    v.removed++;
                end
            end
            for (i = 0; i < BCAST_ENTRIES; i++) begin
                if (bct_valid[i] && elapsed(o.now, bct_start[i]) > retain_sec) begin
                    bct_valid[i] = 1'b0;
                    v.removed++;
                end
            end
        end else if (o.ip != 0 && o.mac != 0) begin
            if (o.mac == MAC_BCAST) begin
                i = -1;
                for (j = 0; j < BCAST_ENTRIES; j++)
                    if (i < 0 && bct_valid[j] && bct_ip[j] == o.ip) i = j;
                if (i < 0) begin
                    for (j = 0; j < BCAST_ENTRIES && bct_valid[j]; j++) ;
                    if (j < BCAST_ENTRIES) begin
                        bct_valid[j] = 1'b1;
                        bct_ip[j]    = o.ip;
                        bct_count[j] = 0;
                        bct_start[j] = o.now;
                        i = j;
                    end else begin
                        v.full = 1'b1;
                    end
                end else if (elapsed(o.now, bct_start[i]) > win_sec) begin
                    bct_count[i] = 0;
                    bct_start[i] = o.now;
                end
                if (i >= 0) begin
                    if (bct_count[i] != COUNT_MAX) bct_count[i]++;
                    if (bct_count[i] > flood_thr) begin
                        v.alarm   = 1'b1;
                        v.ev      = EV_FLOOD;
                        v.old_mac = MAC_BCAST;
                        v.new_mac = MAC_BCAST;
                    end
                end
            end else begin
                laa = o.mac[LAA_BIT];
                j = lookup_mac(o.mac);
                if (j >= 0 && mact_ip[j] != o.ip) begin
                    v.alarm   = 1'b1;
                    v.ev      = EV_REUSE;
                    v.old_mac = o.mac;
                    v.new_mac = o.mac;
                    v.prev_ip = mact_ip[j];
                    mact_ip[j] = o.ip;
                end else begin
                    if (j < 0) begin
                        for (j = 0; j < MAC_ENTRIES && mact_valid[j]; j++) ;
                        if (j < MAC_ENTRIES) begin
                            mact_valid[j] = 1'b1;
                            mact_key[j]   = o.mac;
                            mact_ip[j]    = o.ip;
                        end else begin
                            v.full = 1'b1;
                        end
                    end
                    i = lookup_ip(o.ip);
                    if (i >= 0) begin
                        if (ipt_mac[i] != o.mac) begin
                            v.alarm   = 1'b1;
                            v.ev      = (!ipt_laa[i] && laa) ? EV_LAA : EV_POISON;
                            v.old_mac = ipt_mac[i];
                            v.new_mac = o.mac;
                            ipt_mac[i] = o.mac;
                            ipt_laa[i] = laa;
                        end
                        ipt_seen[i] = o.now;
                    end else begin
                        for (i = 0; i < IP_ENTRIES && ipt_valid[i]; i++) ;
                        if (i < IP_ENTRIES) begin
                            ipt_valid[i] = 1'b1;
                            ipt_key[i]   = o.ip;
                            ipt_mac[i]   = o.mac;
                            ipt_laa[i]   = laa;
                            ipt_seen[i]  = o.now;
                        end else begin
                            v.full = 1'b1;
                        end
                    end
                end
            end
        end
        return v;
    endfunction

    // Driver: present queued transactions with random gaps
    obs_t cur_obs;
    int   send_gap;
    bit   send_burst;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_kind         <= 1'b0;
            s_src_mac_addr <= '0;
            s_src_ip_addr  <= '0;
            s_now_sec      <= '0;
            send_gap       = 0;
            send_burst     = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_verdicts = {expected_verdicts, judge_obs(cur_obs)};
                n_sent++;
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 13);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_obs.size() > 0) begin
                    cur_obs = pending_obs[0];
                    pending_obs.delete(0);
                    s_kind         <= cur_obs.kind;
                    s_src_mac_addr <= cur_obs.mac;
                    s_src_ip_addr  <= cur_obs.ip;
                    s_now_sec      <= cur_obs.now;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result side and check each transaction
    int stall_left;
    bit stall_burst;

    always @(posedge aclk) begin
        verdict_t e;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_left  = 0;
            stall_burst = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("tb: result with nothing expected, event %0d", m_event_type);
                end else begin
                    e = expected_verdicts[0];
                    expected_verdicts.delete(0);
                    n_checked++;
                    if (e.alarm) n_alarms++;
                    if (e.full) n_full++;
                    if (m_alarm !== e.alarm || m_event_type !== e.ev ||
                        m_old_mac_addr !== e.old_mac || m_new_mac_addr !== e.new_mac ||
                        m_previous_ip !== e.prev_ip || m_removed_count !== e.removed ||
                        m_table_full !== e.full) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("tb: mismatch #%0d exp %0d %0d %h %h %h %0d %0d got %0d %0d %h %h %h %0d %0d",
                                     n_checked, e.alarm, e.ev, e.old_mac, e.new_mac,
                                     e.prev_ip, e.removed, e.full, m_alarm, m_event_type,
                                     m_old_mac_addr, m_new_mac_addr, m_previous_ip,
                                     m_removed_count, m_table_full);
                    end
                end
                if ($urandom_range(0, 39) == 0) stall_burst = !stall_burst;
                stall_left = stall_burst ? 0 : $urandom_range(0, 13);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    int idle_cycles;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: watchdog expired after %0d checked", n_checked);
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Stimulus
    bit [47:0] mac_pool[POOL_N];
    bit [31:0] ip_pool [POOL_N];
    bit [31:0] clock_sec;

    task automatic write_reg(bit [1:0] idx, bit [CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FLOOD_WINDOW: win_sec    = val[11:0];
            CFG_FLOOD_THRESH: flood_thr  = val[15:0];
            CFG_STALE:        stale_lim  = val[16:0];
            CFG_BC_RETAIN:    retain_sec = val[11:0];
            default:          stale_lim  = stale_lim;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_obs(bit kind, bit [47:0] mac, bit [31:0] ip, bit [31:0] now);
        obs_t o;
        o.kind = kind;
        o.mac  = mac;
        o.ip   = ip;
        o.now  = now;
        pending_obs = {pending_obs, o};
        n_queued++;
        if (kind) n_sweeps++;
    endtask

    // Hold the sender until every result has come back
    task automatic drain();
        while (n_sent != n_queued || expected_verdicts.size() != 0) @(posedge aclk);
    endtask

    // Random traffic; unicast pairs are drawn from pools of npool addresses
    task automatic queue_random(int count, int npool);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0) clock_sec = clock_sec - $urandom_range(1, 30);
            else if ($urandom_range(0, 99) == 0) clock_sec = clock_sec + $urandom_range(0, 5000);
            else clock_sec = clock_sec + $urandom_range(0, 2);
            if (r < 3)
                queue_obs(1'b1, 48'({$urandom, $urandom}), $urandom, clock_sec);
            else if (r < 30)
                queue_obs(1'b0, MAC_BCAST, ip_pool[$urandom_range(0, BC_POOL_N - 1)],
                          clock_sec);
            else if (r < 34)
                queue_obs(1'b0, 48'({$urandom, $urandom}), 32'd0, clock_sec);
            else if (r < 37)
                queue_obs(1'b0, 48'd0, $urandom, clock_sec);
            else if (r < 40)
                queue_obs(1'b0, 48'({$urandom, $urandom}), $urandom, $urandom);
            else
                queue_obs(1'b0, mac_pool[$urandom_range(0, npool - 1)],
                          ip_pool[$urandom_range(0, npool - 1)], clock_sec);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_FLOOD_WINDOW;
        cfg_wdata  = '0;
        win_sec    = 12'd10;
        flood_thr  = 16'd50;
        stale_lim  = 17'd600;
        retain_sec = 12'd60;
        clock_sec  = 32'd1000;
        for (int k = 0; k < POOL_N; k++) begin
            do mac_pool[k] = 48'({$urandom, $urandom});
            while (mac_pool[k] == 0 || mac_pool[k] == MAC_BCAST);
            do ip_pool[k] = $urandom; while (ip_pool[k] == 0);
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening at reset settings, then a tight flood setting
        queue_obs(1'b0, 48'h0000_0000_0001, 32'd0, 32'd0);
        queue_obs(1'b0, 48'd0, 32'd1, 32'd0);
        queue_obs(1'b0, 48'h0011_2233_4455, 32'd1, 32'd0);
        queue_obs(1'b0, 48'h0011_2233_4455, 32'd1, 32'd5);
        queue_obs(1'b0, 48'h00AA_BBCC_DDEE, 32'd1, 32'd6);
        queue_obs(1'b0, 48'h0233_4455_6677, 32'd1, 32'd7);
        queue_obs(1'b0, 48'h0233_4455_6677, 32'd2, 32'd8);
        queue_obs(1'b0, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_obs(1'b0, 48'h0011_2233_4455, 32'hFFFF_FFFF, 32'd3);
        drain();
        write_reg(CFG_FLOOD_THRESH, 17'd2);
        write_reg(CFG_FLOOD_WINDOW, 17'd5);
        for (int k = 0; k < 4; k++) queue_obs(1'b0, MAC_BCAST, 32'd5, 32'(100 + k));
        queue_obs(1'b0, MAC_BCAST, 32'd5, 32'd120);
        queue_obs(1'b0, MAC_BCAST, 32'd5, 32'd50);
        queue_obs(1'b0, MAC_BCAST, 32'd5, 32'd121);
        queue_obs(1'b0, MAC_BCAST, 32'd5, 32'd122);
        queue_obs(1'b1, 48'd0, 32'd0, 32'd10);
        queue_obs(1'b1, MAC_BCAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_obs(1'b1, 48'd0, 32'd0, 32'hFFFF_FFFF);
        drain();

        // Long retention, low threshold: fill every table
        write_reg(CFG_FLOOD_WINDOW, 17'd1);
        write_reg(CFG_FLOOD_THRESH, 17'd1);
        write_reg(CFG_STALE, 17'd86400);
        write_reg(CFG_BC_RETAIN, 17'd3600);
        queue_random(500, POOL_N);
        drain();

        // Shortest ages: one sweep clears almost everything
        write_reg(CFG_STALE, 17'd1);
        write_reg(CFG_BC_RETAIN, 17'd1);
        clock_sec = clock_sec + 32'd100000;
        queue_obs(1'b1, 48'd0, 32'd0, clock_sec);
        queue_random(400, 40);
        drain();

        // Widest window and highest threshold
        write_reg(CFG_FLOOD_WINDOW, 17'd3600);
        write_reg(CFG_FLOOD_THRESH, 17'd65535);
        write_reg(CFG_STALE, 17'd600);
        write_reg(CFG_BC_RETAIN, 17'd60);
        queue_random(250, 64);
        drain();

        // Mid settings with a small pool for frequent rebinding
        write_reg(CFG_FLOOD_WINDOW, 17'd10);
        write_reg(CFG_FLOOD_THRESH, 17'd3);
        write_reg(CFG_STALE, 17'd20);
        write_reg(CFG_BC_RETAIN, 17'd15);
        queue_random(280, 24);
        drain();
        repeat (20) @(posedge aclk);

        $display("tb: %0d transactions checked, %0d sweeps, %0d alarms, %0d table-full drops",
                 n_checked, n_sweeps, n_alarms, n_full);
        $display("tb: %0d mismatches", n_mismatch);
        if (n_mismatch == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/arpd_pkg.sv
rtl/arpd_ram.sv
rtl/arp_mac_spoof_detector.sv
rtl/arpd_checker.sv
dv/tb.sv
